// ===== sv/sst_pkg.sv =====
// shared types and constants of the step sequencer track
package sst_pkg;

  localparam int unsigned STEPS_DEF     = 16;
  localparam int unsigned TICK_BITS_DEF = 32;
  localparam int unsigned TICK_W        = 32;

  // pulses per quarter note, step and gate defaults follow from it
  localparam int unsigned PPQN     = 192;
  localparam logic [7:0]  TPS_RST  = 8'(PPQN / 4);
  localparam logic [7:0]  GATE_RST = 8'(PPQN / 8);

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PLAY_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MUTED      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TPS        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_LEN   = 3'd5;

  localparam logic [2:0] MODE_FWD  = 3'd0;
  localparam logic [2:0] MODE_BWD  = 3'd1;
  localparam logic [2:0] MODE_PING = 3'd2;
  localparam logic [2:0] MODE_PEND = 3'd3;
  localparam logic [2:0] MODE_RAND = 3'd4;

  typedef struct packed {
    logic        action;
    logic [31:0] tick_time;
    logic [15:0] random_value;
    logic [3:0]  entry_index;
    logic        entry_active;
    logic [6:0]  entry_note;
  } sst_in_t;

  typedef struct packed {
    logic [3:0] current_step;
    logic       step_advanced;
    logic       gate_level;
    logic       gate_out;
    logic [6:0] note_out;
  } sst_out_t;

  // status of the bit-serial engine
  typedef struct packed {
    logic       done;
    logic       tick_zero;
    logic [3:0] rnd_rem;
    logic       old_ge;
    logic       add_carry;
  } sst_ser_t;

  typedef struct packed {
    logic [3:0] step;
    logic       moving_down;
  } sst_pos_t;

endpackage

// ===== sv/sst_serial.sv =====
// bit-serial engine: tick modulo period, random modulo span, fall compare and fall time add
module sst_serial #(
  parameter int TW = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TW-1:0]     tick,
  input  logic [TW-1:0]     fall_time,
  input  logic [15:0]       rnd,
  input  logic [7:0]        period,
  input  logic [7:0]        glen,
  input  logic [4:0]        span,
  output sst_pkg::sst_ser_t res,
  output logic [TW-1:0]     cand
);

  localparam int CW = $clog2(TW + 1);

  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [TW-1:0] msb_sh_r, msb_sh_nxt, lsb_sh_r, lsb_sh_nxt;
  logic [TW-1:0] ft_sh_r, ft_sh_nxt, cand_r, cand_nxt;
  logic [15:0]   rnd_sh_r, rnd_sh_nxt;
  logic [7:0]    glen_sh_r, glen_sh_nxt, trem_r, trem_nxt;
  logic [3:0]    rrem_r, rrem_nxt;
  logic          carry_r, carry_nxt, dec_r, dec_nxt, ge_r, ge_nxt;
  logic [8:0]    tsh;
  logic [4:0]    rsh;
  logic          rnd_en, a_bit, b_bit, c_bit, sum_bit;

  always_comb begin
    tsh     = {trem_r, msb_sh_r[TW-1]};
    rsh     = {rrem_r, rnd_sh_r[15]};
    // random value has 16 bits, taken in the first 16 steps
    rnd_en  = cnt_r > CW'(TW - 16);
    a_bit   = lsb_sh_r[0];
    b_bit   = glen_sh_r[0];
    c_bit   = carry_r;
    sum_bit = a_bit ^ b_bit ^ c_bit;

    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    cnt_nxt     = cnt_r;
    msb_sh_nxt  = msb_sh_r;
    lsb_sh_nxt  = lsb_sh_r;
    ft_sh_nxt   = ft_sh_r;
    cand_nxt    = cand_r;
    rnd_sh_nxt  = rnd_sh_r;
    glen_sh_nxt = glen_sh_r;
    trem_nxt    = trem_r;
    rrem_nxt    = rrem_r;
    carry_nxt   = carry_r;
    dec_nxt     = dec_r;
    ge_nxt      = ge_r;

    if (start) begin
      busy_nxt    = 1'b1;
      cnt_nxt     = CW'(TW);
      msb_sh_nxt  = tick;
      lsb_sh_nxt  = tick;
      ft_sh_nxt   = fall_time;
      rnd_sh_nxt  = rnd;
      glen_sh_nxt = glen;
      trem_nxt    = '0;
      rrem_nxt    = '0;
      carry_nxt   = 1'b0;
      dec_nxt     = 1'b0;
      ge_nxt      = 1'b0;
    end else if (busy_r) begin
      // restoring remainder, one tick bit per cycle, msb first
      trem_nxt = (tsh >= {1'b0, period}) ? 8'(tsh - {1'b0, period}) : tsh[7:0];
      if (rnd_en) begin
        rrem_nxt   = (rsh >= span) ? 4'(rsh - span) : rsh[3:0];
        rnd_sh_nxt = {rnd_sh_r[14:0], 1'b0};
      end
      // first differing bit from the top decides tick against old fall time
      if (!dec_r && (msb_sh_r[TW-1] != ft_sh_r[TW-1])) begin
        dec_nxt = 1'b1;
        ge_nxt  = msb_sh_r[TW-1];
      end
      msb_sh_nxt  = {msb_sh_r[TW-2:0], 1'b0};
      ft_sh_nxt   = {ft_sh_r[TW-2:0], 1'b0};
      // ripple add of gate length, lsb first
      lsb_sh_nxt  = {1'b0, lsb_sh_r[TW-1:1]};
      glen_sh_nxt = {1'b0, glen_sh_r[7:1]};
      cand_nxt    = {sum_bit, cand_r[TW-1:1]};
      carry_nxt   = (a_bit & b_bit) | (a_bit & c_bit) | (b_bit & c_bit);
      cnt_nxt     = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    msb_sh_r  <= msb_sh_nxt;
    lsb_sh_r  <= lsb_sh_nxt;
    ft_sh_r   <= ft_sh_nxt;
    cand_r    <= cand_nxt;
    rnd_sh_r  <= rnd_sh_nxt;
    glen_sh_r <= glen_sh_nxt;
    trem_r    <= trem_nxt;
    rrem_r    <= rrem_nxt;
    carry_r   <= carry_nxt;
    dec_r     <= dec_nxt;
    ge_r      <= ge_nxt;
  end

  assign res.done      = done_r;
  assign res.tick_zero = (trem_r == 8'd0);
  assign res.rnd_rem   = rrem_r;
  assign res.old_ge    = !dec_r || ge_r;
  assign res.add_carry = carry_r;
  assign cand          = cand_r;

endmodule

// ===== sv/sst_step_next.sv =====
// next playing step and direction for each play mode
module sst_step_next (
  input  logic [2:0]        mode,
  input  logic [3:0]        lo,
  input  logic [3:0]        hi,
  input  logic [3:0]        rnd_rem,
  input  logic              started,
  input  sst_pkg::sst_pos_t cur,
  output sst_pkg::sst_pos_t nxt
);

  logic [3:0] rnd_step;

  always_comb begin
    rnd_step = 4'(rnd_rem + lo);
    nxt      = cur;
    if (!started) begin
      if (mode == sst_pkg::MODE_BWD) begin
        nxt.step = hi;
      end else if (mode == sst_pkg::MODE_RAND) begin
        nxt.step = rnd_step;
      end else begin
        nxt.step = lo;
      end
    end else begin
      unique case (mode)
        sst_pkg::MODE_BWD: begin
          nxt.step = (cur.step <= lo) ? hi : cur.step - 4'd1;
        end
        sst_pkg::MODE_PING, sst_pkg::MODE_PEND: begin
          if (!cur.moving_down && cur.step >= hi) begin
            nxt.moving_down = 1'b1;
            // ping-pong steps away from the end, pendulum repeats it
            if (mode == sst_pkg::MODE_PING && cur.step > lo) nxt.step = cur.step - 4'd1;
          end else if (cur.moving_down && cur.step <= lo) begin
            nxt.moving_down = 1'b0;
            if (mode == sst_pkg::MODE_PING && cur.step < hi) nxt.step = cur.step + 4'd1;
          end else if (cur.moving_down) begin
            nxt.step = cur.step - 4'd1;
          end else begin
            nxt.step = cur.step + 4'd1;
          end
        end
        sst_pkg::MODE_RAND: begin
          nxt.step = rnd_step;
        end
        default: begin
          nxt.step = (cur.step >= hi) ? lo : cur.step + 4'd1;
        end
      endcase
    end
  end

endmodule

// ===== sv/sst_step_mem.sv =====
// step table memory with per-entry valid bits cleared by reset
module sst_step_mem #(
  parameter int STEPS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       we,
  input  logic [3:0] waddr,
  input  logic [7:0] wdata,
  input  logic [3:0] raddr,
  output logic [7:0] rdata
);

  localparam int AW = $clog2(STEPS);

  logic [7:0]      mem [STEPS];
  logic [STEPS-1:0] valid_r;
  logic [AW+3:0]   wext, rext;
  logic [AW-1:0]   wa, ra;
  logic            w_in, r_in;
  logic [7:0]      rd_r;
  logic            rv_r;

  always_comb begin
    wext = (AW + 4)'(waddr);
    rext = (AW + 4)'(raddr);
    wa   = wext[AW-1:0];
    ra   = rext[AW-1:0];
    // indexes past the table are dropped on write and read as empty
    w_in = {28'd0, waddr} < 32'(STEPS);
    r_in = {28'd0, raddr} < 32'(STEPS);
  end

  always_ff @(posedge clk) begin
    if (we && w_in) mem[wa] <= wdata;
    rd_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rv_r    <= 1'b0;
    end else begin
      if (we && w_in) valid_r[wa] <= 1'b1;
      rv_r <= valid_r[ra] && r_in;
    end
  end

  assign rdata = rv_r ? rd_r : 8'd0;

endmodule

// ===== sv/step_sequencer_track_core.sv =====
// step sequencer track top level: control sequencer, state and output register
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall    sst_pkg::sst_in_t
//   out_     output     out_valid/out_stall  sst_pkg::sst_out_t
//   cfg_     input      cfg_we               cfg_idx, cfg_wdata
//
// a tick request runs the bit-serial engine over min(TICK_BITS,32) tick bits, one tick bit per cycle,
// then passes S_STEP and S_GATE when the step advances, and ends in S_DONE
// a table write request goes straight from S_IDLE to S_DONE
// reset is synchronous, active low; the step table reads as empty until written
// one request at a time; a finished result waits in the output register under out_stall
module step_sequencer_track_core #(
  parameter int STEPS     = sst_pkg::STEPS_DEF,
  parameter int TICK_BITS = sst_pkg::TICK_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  sst_pkg::sst_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output sst_pkg::sst_out_t               out_data,
  input  logic                            cfg_we,
  input  logic [sst_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [7:0]                      cfg_wdata
);

  localparam int TW = (TICK_BITS < int'(sst_pkg::TICK_W)) ? TICK_BITS : int'(sst_pkg::TICK_W);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RUN  = 5'b00010,
    S_STEP = 5'b00100,
    S_GATE = 5'b01000,
    S_DONE = 5'b10000
  } sst_state_t;

  sst_state_t state_r, state_nxt;

  logic [2:0] mode_r;
  logic [3:0] first_r, last_r;
  logic       muted_r;
  logic [7:0] tps_r, glen_cfg_r;

  logic [3:0] lo, hi;
  logic [4:0] span;
  logic [7:0] period, glen;

  logic [3:0]    step_r, step_nxt;
  logic          started_r, started_nxt, down_r, down_nxt;
  logic          gate_now_r, gate_now_nxt, gate_mask_r, gate_mask_nxt;
  logic          fall_pend_r, fall_pend_nxt, adv_r, adv_nxt;
  logic [TW-1:0] fall_time_r, fall_time_nxt;
  logic [6:0]    note_r, note_nxt;
  logic          out_valid_r, out_valid_nxt;
  sst_pkg::sst_out_t out_data_r;

  logic              in_acc, mem_we, ser_start, out_load;
  sst_pkg::sst_ser_t ser;
  logic [TW-1:0]     cand;
  sst_pkg::sst_pos_t pos_cur, pos_nxt;
  logic [7:0]        entry;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= sst_pkg::MODE_FWD;
      first_r    <= 4'd0;
      last_r     <= 4'd15;
      muted_r    <= 1'b0;
      tps_r      <= sst_pkg::TPS_RST;
      glen_cfg_r <= sst_pkg::GATE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        sst_pkg::REG_PLAY_MODE:  mode_r     <= cfg_wdata[2:0];
        sst_pkg::REG_FIRST_STEP: first_r    <= cfg_wdata[3:0];
        sst_pkg::REG_LAST_STEP:  last_r     <= cfg_wdata[3:0];
        sst_pkg::REG_MUTED:      muted_r    <= cfg_wdata[0];
        sst_pkg::REG_TPS:        tps_r      <= cfg_wdata;
        sst_pkg::REG_GATE_LEN:   glen_cfg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    lo     = first_r;
    hi     = (last_r < first_r) ? first_r : last_r;
    span   = {1'b0, hi} - {1'b0, lo} + 5'd1;
    period = (tps_r == 8'd0) ? 8'd1 : tps_r;
    glen   = (glen_cfg_r < period) ? glen_cfg_r : period - 8'd1;
  end

  sst_serial #(
    .TW (TW)
  ) u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (ser_start),
    .tick      (in_data.tick_time[TW-1:0]),
    .fall_time (fall_time_r),
    .rnd       (in_data.random_value),
    .period    (period),
    .glen      (glen),
    .span      (span),
    .res       (ser),
    .cand      (cand)
  );

  assign pos_cur.step        = step_r;
  assign pos_cur.moving_down = down_r;

  sst_step_next u_next (
    .mode    (mode_r),
    .lo      (lo),
    .hi      (hi),
    .rnd_rem (ser.rnd_rem),
    .started (started_r),
    .cur     (pos_cur),
    .nxt     (pos_nxt)
  );

  sst_step_mem #(
    .STEPS (STEPS)
  ) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (in_data.entry_index),
    .wdata ({in_data.entry_active, in_data.entry_note}),
    .raddr (pos_nxt.step),
    .rdata (entry)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    started_nxt   = started_r;
    down_nxt      = down_r;
    gate_now_nxt  = gate_now_r;
    gate_mask_nxt = gate_mask_r;
    fall_pend_nxt = fall_pend_r;
    fall_time_nxt = fall_time_r;
    note_nxt      = note_r;
    adv_nxt       = adv_r;
    mem_we        = 1'b0;
    ser_start     = 1'b0;
    out_load      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          adv_nxt = 1'b0;
          if (in_data.action) begin
            mem_we    = 1'b1;
            state_nxt = S_DONE;
          end else begin
            ser_start = 1'b1;
            state_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (ser.done) begin
          if (ser.tick_zero) begin
            state_nxt = S_STEP;
          end else begin
            if (fall_pend_r && ser.old_ge) begin
              gate_now_nxt  = 1'b0;
              gate_mask_nxt = 1'b0;
              fall_pend_nxt = 1'b0;
            end
            state_nxt = S_DONE;
          end
        end
      end
      S_STEP: begin
        // table read of the new step is registered here
        step_nxt    = pos_nxt.step;
        down_nxt    = pos_nxt.moving_down;
        started_nxt = 1'b1;
        state_nxt   = S_GATE;
      end
      S_GATE: begin
        adv_nxt  = 1'b1;
        note_nxt = entry[6:0];
        if (entry[7]) begin
          fall_time_nxt = cand;
          // new fall is already due when the add wraps or the length is zero
          if (ser.add_carry || glen == 8'd0) begin
            gate_now_nxt  = 1'b0;
            gate_mask_nxt = 1'b0;
            fall_pend_nxt = 1'b0;
          end else begin
            gate_now_nxt  = 1'b1;
            gate_mask_nxt = !muted_r;
            fall_pend_nxt = 1'b1;
          end
        end else if (fall_pend_r && ser.old_ge) begin
          gate_now_nxt  = 1'b0;
          gate_mask_nxt = 1'b0;
          fall_pend_nxt = 1'b0;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= 4'd0;
      started_r   <= 1'b0;
      down_r      <= 1'b0;
      gate_now_r  <= 1'b0;
      gate_mask_r <= 1'b0;
      fall_pend_r <= 1'b0;
      fall_time_r <= '0;
      note_r      <= 7'd0;
      adv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      started_r   <= started_nxt;
      down_r      <= down_nxt;
      gate_now_r  <= gate_now_nxt;
      gate_mask_r <= gate_mask_nxt;
      fall_pend_r <= fall_pend_nxt;
      fall_time_r <= fall_time_nxt;
      note_r      <= note_nxt;
      adv_r       <= adv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.current_step  <= step_r;
      out_data_r.step_advanced <= adv_r;
      out_data_r.gate_level    <= gate_now_r;
      out_data_r.gate_out      <= gate_mask_r;
      out_data_r.note_out      <= note_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/sst_checker.sv =====
// port-level checker for the step sequencer track, bound to the top level
module sst_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input sst_pkg::sst_out_t out_data
);

  // one request in flight: the input closes right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  // the muted gate can only be high while the internal gate is high
  a_gate_masked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_data.gate_out || out_data.gate_level)
    else $error("gate_out high with gate_level low");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

endmodule

bind step_sequencer_track_core sst_checker u_sst_checker (.*);
